// ----- sv/mvm_pkg.sv -----
// Shared types and constants for the matrix-vector multiply block.
// No dependencies; imported by every other file in sv/.
package mvm_pkg;

    localparam int LANES          = 4;
    localparam int ELEM_W         = 16;
    localparam int PROD_W         = 2 * ELEM_W;
    localparam int ACC_W          = 40;
    localparam int SUM_W          = 42;
    localparam int CFG_W          = 9;
    localparam int IDX_W          = 10;
    localparam int MAX_GROUPS_DEF = 256;

    // One group of four Q1.15 lanes, lane 0 in the low bits
    typedef logic [LANES-1:0][ELEM_W-1:0] t_group;

    // Row bookkeeping that travels with a matrix word down the pipe
    typedef struct packed {
        logic             end_row;
        logic             last;
        logic [IDX_W-1:0] row_idx;
    } t_row_tag;

endpackage

// ----- sv/mvm_vec_store.sv -----
// Vector group store: one write port, one registered read port.
// Depends on mvm_pkg for the group word type.
module mvm_vec_store import mvm_pkg::*; #(
    parameter int DEPTH = MAX_GROUPS_DEF,
    localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_group        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_group        o_rd_data
);

    t_group r_mem [DEPTH];
    t_group r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/mvm_mac.sv -----
// Lane multiply, lane accumulate, lane reduction and output register.
// Depends on mvm_pkg for lane, width and row tag definitions.
module mvm_mac import mvm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s1_valid,
    input  t_group                  i_s1_elem,
    input  t_group                  i_s1_vec,
    input  t_row_tag                i_s1_tag,
    output logic                    o_s1_hold,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic signed [SUM_W-1:0] o_row_sum,
    output logic [IDX_W-1:0]        o_row_index,
    output logic                    o_last_row
);

    logic                    r_v2;
    logic signed [PROD_W-1:0] r_prod [LANES];
    t_row_tag                r_tag2;
    logic signed [ACC_W-1:0] r_acc [LANES];
    logic                    r_v3;
    logic signed [ACC_W-1:0] r_fin [LANES];
    t_row_tag                r_tag3;
    logic                    r_v4;
    logic signed [SUM_W-1:0] r_sum;
    t_row_tag                r_tag4;

    logic                    h4, h3, h2, c2;
    logic signed [PROD_W-1:0] n_prod [LANES];
    logic signed [ACC_W-1:0] n_lane [LANES];
    logic signed [SUM_W-1:0] n_sum;

    // hold chain: only row-ending words need a free slot downstream
    assign h4 = r_v4 & i_out_stall;
    assign h3 = r_v3 & h4;
    assign h2 = r_v2 & r_tag2.end_row & h3;
    assign c2 = r_v2 & ~h2;
    assign o_s1_hold = i_s1_valid & h2;

    // lane products and lane sums
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_prod[k] = $signed(i_s1_elem[k]) * $signed(i_s1_vec[k]);
            n_lane[k] = r_acc[k] + ACC_W'(r_prod[k]);
        end
    end

    // reduction of the four finished lanes
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < LANES; k++) begin
            n_sum = n_sum + SUM_W'(r_fin[k]);
        end
    end

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (!h2) begin
            r_v2 <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!h2) begin
            r_prod <= n_prod;
            r_tag2 <= i_s1_tag;
        end
    end

    // accumulators: clear when the row's total moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANES; k++) begin
                r_acc[k] <= '0;
            end
        end else if (c2) begin
            for (int k = 0; k < LANES; k++) begin
                r_acc[k] <= r_tag2.end_row ? '0 : n_lane[k];
            end
        end
    end

    // finished lane totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (!h3) begin
            r_v3 <= c2 & r_tag2.end_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!h3 && c2 && r_tag2.end_row) begin
            r_fin  <= n_lane;
            r_tag3 <= r_tag2;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (!h4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!h4) begin
            r_sum  <= n_sum;
            r_tag4 <= r_tag3;
        end
    end

    assign o_out_valid = r_v4;
    assign o_row_sum   = r_sum;
    assign o_row_index = r_tag4.row_idx;
    assign o_last_row  = r_tag4.last;

endmodule

// ----- sv/matrix_vector_multiply.sv -----
// Top level of the four-lane matrix-vector multiply: config register, group counters,
// input register and hookup of the vector store and the MAC pipe.
// Depends on mvm_pkg, mvm_vec_store and mvm_mac.
//
//   channel   handshake              word
//   input     i_in_valid / o_in_stall  i_func, i_elem_zero .. i_elem_three
//   result    o_out_valid / i_out_stall o_row_sum, o_row_index, o_last_row
//   config    i_cfg_valid / o_cfg_ready i_cfg_data (groups per row)
//
// One input word per cycle while o_in_stall is low. A row total passes through four
// registers after its last matrix word is taken: input and store read, product register,
// lane totals, reduction register.
// Reset clears counters, accumulators and valid bits; the vector store is not
// cleared and must be loaded before use. Output stall backs up only through
// row-ending words, so input keeps flowing until the pipe truly fills.
module matrix_vector_multiply import mvm_pkg::*; #(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_func,
    input  logic signed [ELEM_W-1:0] i_elem_zero,
    input  logic signed [ELEM_W-1:0] i_elem_one,
    input  logic signed [ELEM_W-1:0] i_elem_two,
    input  logic signed [ELEM_W-1:0] i_elem_three,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_W-1:0]         i_cfg_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [SUM_W-1:0]  o_row_sum,
    output logic [IDX_W-1:0]         o_row_index,
    output logic                     o_last_row
);

    localparam int CNT_W = $clog2(MAX_GROUPS > 1 ? MAX_GROUPS : 2);
    localparam int G_W   = CNT_W + 1;
    localparam int ROW_W = CNT_W + 2;

    logic [CFG_W-1:0] r_cfg;
    logic [CNT_W-1:0] r_vlg, n_vlg;
    logic [CNT_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_v1;
    t_group           r_e1;
    t_row_tag         r_tag1;

    logic [G_W-1:0]   g, vlg_ext, vlg_inc, slot, col_ext, col_inc, col_sel;
    logic [ROW_W:0]   rows, row_inc;
    logic             accept, acc_vec, acc_mat, end_row, last, s1_hold;
    t_group           in_group, rd_group;
    t_row_tag         tag0;

    assign in_group = {i_elem_three, i_elem_two, i_elem_one, i_elem_zero};
    assign accept   = i_in_valid & ~s1_hold;
    assign acc_vec  = accept & ~i_func;
    assign acc_mat  = accept & i_func;
    assign o_in_stall  = s1_hold;
    assign o_cfg_ready = 1'b1;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // effective groups per row, clamped to 1..MAX_GROUPS
    always_comb begin
        if (r_cfg == '0) begin
            g = G_W'(1);
        end else if (int'(r_cfg) > MAX_GROUPS) begin
            g = G_W'(MAX_GROUPS);
        end else begin
            g = G_W'(r_cfg);
        end
    end

    // counter next values; a counter past the limit uses the last slot and wraps
    always_comb begin
        vlg_ext = {1'b0, r_vlg};
        vlg_inc = vlg_ext + G_W'(1);
        slot    = (vlg_ext >= g) ? g - G_W'(1) : vlg_ext;
        n_vlg   = (vlg_inc >= g) ? '0 : vlg_inc[CNT_W-1:0];

        col_ext = {1'b0, r_col};
        col_inc = col_ext + G_W'(1);
        col_sel = (col_ext >= g) ? g - G_W'(1) : col_ext;
        end_row = (col_inc >= g);
        n_col   = end_row ? '0 : col_inc[CNT_W-1:0];

        rows    = {g, 2'b00};
        row_inc = {1'b0, r_row} + (ROW_W + 1)'(1);
        last    = (row_inc >= rows);
        n_row   = last ? '0 : row_inc[ROW_W-1:0];

        tag0.end_row = end_row;
        tag0.last    = last;
        tag0.row_idx = IDX_W'(r_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlg <= '0;
            r_col <= '0;
            r_row <= '0;
        end else begin
            if (acc_vec) begin
                r_vlg <= n_vlg;
            end
            if (acc_mat) begin
                r_col <= n_col;
                if (end_row) begin
                    r_row <= n_row;
                end
            end
        end
    end

    // input register for matrix words, alongside the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (!s1_hold) begin
            r_v1 <= acc_mat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_mat) begin
            r_e1   <= in_group;
            r_tag1 <= tag0;
        end
    end

    mvm_vec_store #(
        .DEPTH (MAX_GROUPS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (acc_vec),
        .i_wr_addr (slot[CNT_W-1:0]),
        .i_wr_data (in_group),
        .i_rd_en   (acc_mat),
        .i_rd_addr (col_sel[CNT_W-1:0]),
        .o_rd_data (rd_group)
    );

    mvm_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (r_v1),
        .i_s1_elem   (r_e1),
        .i_s1_vec    (rd_group),
        .i_s1_tag    (r_tag1),
        .o_s1_hold   (s1_hold),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_row_sum   (o_row_sum),
        .o_row_index (o_row_index),
        .o_last_row  (o_last_row)
    );

endmodule
